FILE: rtl/generational_entity_slot_table_top_defines.svh
// Assertion macros used by the slot table top level.
`ifndef GENERATIONAL_ENTITY_SLOT_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_ENTITY_SLOT_TABLE_TOP_DEFINES_SVH

// Checked at every clock edge while reset is released.
`define GEST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define GEST_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/gest_pkg.sv
// Shared constants, codes, types and helpers of the generational slot table.
package gest_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 1024;

  localparam int unsigned LANES       = 16;
  localparam int unsigned LANE_W      = 4;
  localparam int unsigned LIFE_W      = 2;
  localparam int unsigned LIFE_WORD_W = LANES * LIFE_W;
  localparam int unsigned GEN_W       = 32;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned SLOT_W      = 11;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd2;
  localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  localparam logic [LIFE_W-1:0] LS_INACTIVE = 2'd0;
  localparam logic [LIFE_W-1:0] LS_PEND_ADD = 2'd1;
  localparam logic [LIFE_W-1:0] LS_ACTIVE   = 2'd2;
  localparam logic [LIFE_W-1:0] LS_PEND_REM = 2'd3;

  typedef struct packed {
    logic [LANES-1:0] free;
    logic [LANES-1:0] live;
  } lane_vec_t;

  function automatic logic [LANE_W-1:0] first_set(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = LANE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/gest_ram.sv
// Generic single write port RAM with one registered read port.
module gest_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gest_lane_unit.sv
// Shared lane evaluator: classifies the sixteen life states of one table word.
module gest_lane_unit #(
  parameter int unsigned NUM_SLOTS = gest_pkg::NUM_SLOTS_DEF,
  localparam int unsigned WORDS = (NUM_SLOTS + gest_pkg::LANES - 1) / gest_pkg::LANES,
  localparam int unsigned WAW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic [gest_pkg::LIFE_WORD_W-1:0] life_word_i,
  input  logic [WAW-1:0]                   word_idx_i,
  input  logic [gest_pkg::LANE_W-1:0]      lo_lane_i,
  output gest_pkg::lane_vec_t              vec_o,
  output logic [gest_pkg::LIFE_WORD_W-1:0] commit_word_o
);
  import gest_pkg::*;

  always_comb begin
    logic [LIFE_W-1:0] lane_st;
    logic [31:0]       slot_idx;
    logic              in_range;
    vec_o         = '0;
    commit_word_o = life_word_i;
    for (int l = 0; l < LANES; l++) begin
      lane_st      = life_word_i[l*LIFE_W +: LIFE_W];
      slot_idx     = 32'({word_idx_i, LANE_W'(l)});
      in_range     = slot_idx < NUM_SLOTS;
      vec_o.free[l] = in_range && (lane_st == LS_INACTIVE);
      vec_o.live[l] = in_range && lane_st[1] && (LANE_W'(l) >= lo_lane_i);
      case (lane_st)
        LS_PEND_ADD: commit_word_o[l*LIFE_W +: LIFE_W] = LS_ACTIVE;
        LS_PEND_REM: commit_word_o[l*LIFE_W +: LIFE_W] = LS_INACTIVE;
        default:     commit_word_o[l*LIFE_W +: LIFE_W] = lane_st;
      endcase
    end
  end

endmodule

FILE: rtl/generational_entity_slot_table_top.sv
// Top level of the generational entity slot table: sequencer, tables and output register.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  operation_i slot_i generation_i mask_i
//                                              allow_pending_i
//   out      source     out_valid_o/out_ready_i status_o result_slot_o result_generation_o
//
// After reset a clearing pass writes every life word to zero before a transaction is taken.
// Add and commit scan the life words from word zero; remove and check read the slot's entry.
// Query scans from the slot after slot_i, or from slot zero if slot_i is negative, and reads
// candidate masks until one matches; life words pass sixteen slots a cycle between mask reads.
// A finished transaction waits in the output register while the next one is accepted.
`include "generational_entity_slot_table_top_defines.svh"

module generational_entity_slot_table_top #(
  parameter int unsigned NUM_SLOTS = gest_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gest_pkg::OP_W-1:0]     operation_i,
  input  logic signed [gest_pkg::SLOT_W-1:0] slot_i,
  input  logic [gest_pkg::GEN_W-1:0]    generation_i,
  input  logic [gest_pkg::MASK_W-1:0]   mask_i,
  input  logic                          allow_pending_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gest_pkg::STATUS_W-1:0] status_o,
  output logic signed [gest_pkg::SLOT_W-1:0] result_slot_o,
  output logic [gest_pkg::GEN_W-1:0]    result_generation_o
);
  import gest_pkg::*;

  localparam int unsigned WORDS = (NUM_SLOTS + LANES - 1) / LANES;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam int unsigned SW    = WAW + LANE_W;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  localparam int unsigned S_W = 4;
  localparam logic [S_W-1:0] S_CLEAR  = 4'd0;
  localparam logic [S_W-1:0] S_IDLE   = 4'd1;
  localparam logic [S_W-1:0] S_ADD    = 4'd2;
  localparam logic [S_W-1:0] S_HCHK   = 4'd3;
  localparam logic [S_W-1:0] S_COMMIT = 4'd4;
  localparam logic [S_W-1:0] S_QLIFE  = 4'd5;
  localparam logic [S_W-1:0] S_QMASK  = 4'd6;
  localparam logic [S_W-1:0] S_DONE   = 4'd7;

  logic [S_W-1:0]      state_q, state_d;
  logic [WAW-1:0]      word_q, word_d;
  logic [LANE_W-1:0]   lane_q, lane_d;
  logic [LANE_W-1:0]   lo_lane_q, lo_lane_d;
  logic [LANES-1:0]    cand_q, cand_d;
  logic [GEN_W-1:0]    gen_ctr_q, gen_ctr_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [GEN_W-1:0]    res_gen_q, res_gen_d;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [GEN_W-1:0]    out_gen_q;

  logic [OP_W-1:0]     op_q;
  logic                allow_q;
  logic [GEN_W-1:0]    gen_in_q;
  logic [MASK_W-1:0]   mask_q;

  logic [WAW-1:0]         life_raddr;
  logic                   life_we;
  logic [LIFE_WORD_W-1:0] life_wdata;
  logic [LIFE_WORD_W-1:0] life_rdata;
  logic [LIFE_WORD_W-1:0] commit_word;
  lane_vec_t              vec;

  logic [IDX_W-1:0]  tbl_raddr;
  logic [IDX_W-1:0]  tbl_waddr;
  logic              tbl_we;
  logic [GEN_W-1:0]  gen_rdata;
  logic [MASK_W-1:0] mask_rdata;

  logic [31:0]       slot_ext;
  logic              slot_in_range;
  logic [31:0]       q_start;
  logic              q_ok;
  logic [LANE_W-1:0] add_lane;
  logic [SW-1:0]     add_idx;
  logic [SW-1:0]     cur_idx;
  logic              go_done;

  assign slot_ext      = {22'd0, slot_i[9:0]};
  assign slot_in_range = !slot_i[SLOT_W-1] && (slot_ext < NUM_SLOTS);
  assign q_start       = slot_i[SLOT_W-1] ? 32'd0 : slot_ext + 32'd1;
  assign q_ok          = q_start < NUM_SLOTS;
  assign add_lane      = first_set(vec.free);
  assign add_idx       = {word_q, add_lane};
  assign cur_idx       = {word_q, lane_q};
  assign tbl_waddr     = add_idx[IDX_W-1:0];
  assign go_done       = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign result_slot_o       = out_slot_q;
  assign result_generation_o = out_gen_q;

  gest_ram #(
    .WIDTH(LIFE_WORD_W),
    .DEPTH(WORDS)
  ) u_life_ram (
    .clk_i  (clk_i),
    .we_i   (life_we),
    .waddr_i(word_q),
    .wdata_i(life_wdata),
    .raddr_i(life_raddr),
    .rdata_o(life_rdata)
  );

  gest_ram #(
    .WIDTH(GEN_W),
    .DEPTH(NUM_SLOTS)
  ) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(gen_ctr_q),
    .raddr_i(tbl_raddr),
    .rdata_o(gen_rdata)
  );

  gest_ram #(
    .WIDTH(MASK_W),
    .DEPTH(NUM_SLOTS)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(mask_q),
    .raddr_i(tbl_raddr),
    .rdata_o(mask_rdata)
  );

  gest_lane_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_lane_unit (
    .life_word_i  (life_rdata),
    .word_idx_i   (word_q),
    .lo_lane_i    (lo_lane_q),
    .vec_o        (vec),
    .commit_word_o(commit_word)
  );

  always_comb begin
    logic [LIFE_W-1:0] h_st;
    logic              h_ok;
    logic [LANE_W-1:0] ql;
    logic [SW-1:0]     q_idx;
    logic [31:0]       idx32;
    state_d      = state_q;
    word_d       = word_q;
    lane_d       = lane_q;
    lo_lane_d    = lo_lane_q;
    cand_d       = cand_q;
    gen_ctr_d    = gen_ctr_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_gen_d    = res_gen_q;
    life_raddr   = word_q + WAW'(1);
    life_we      = 1'b0;
    life_wdata   = life_rdata;
    tbl_raddr    = cur_idx[IDX_W-1:0];
    tbl_we       = 1'b0;
    h_st         = life_rdata[lane_q*LIFE_W +: LIFE_W];
    h_ok         = (allow_q ? (h_st != LS_INACTIVE) : h_st[1]) && (gen_rdata == gen_in_q);
    ql           = '0;
    q_idx        = cur_idx;
    idx32        = 32'(cur_idx);
    unique case (state_q)
      S_CLEAR: begin
        life_we    = 1'b1;
        life_wdata = '0;
        if (word_q == LAST_WORD) begin
          state_d = S_IDLE;
        end else begin
          word_d = word_q + WAW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_slot_d   = '1;
          res_gen_d    = '0;
          state_d      = S_DONE;
          unique case (operation_i) inside
            OP_ADD: begin
              word_d     = '0;
              life_raddr = '0;
              state_d    = S_ADD;
            end
            OP_COMMIT: begin
              word_d     = '0;
              life_raddr = '0;
              state_d    = S_COMMIT;
            end
            OP_REMOVE, OP_CHECK: begin
              if (slot_in_range) begin
                word_d     = slot_ext[LANE_W +: WAW];
                lane_d     = slot_ext[LANE_W-1:0];
                life_raddr = slot_ext[LANE_W +: WAW];
                tbl_raddr  = slot_ext[IDX_W-1:0];
                state_d    = S_HCHK;
              end else begin
                res_status_d = ST_INVALID;
              end
            end
            OP_QUERY: begin
              if (q_ok) begin
                word_d     = q_start[LANE_W +: WAW];
                lo_lane_d  = q_start[LANE_W-1:0];
                life_raddr = q_start[LANE_W +: WAW];
                state_d    = S_QLIFE;
              end else begin
                res_status_d = ST_NOMATCH;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ADD: begin
        if (|vec.free) begin
          life_we    = 1'b1;
          life_wdata[add_lane*LIFE_W +: LIFE_W] = LS_PEND_ADD;
          tbl_we     = 1'b1;
          idx32      = 32'(add_idx);
          res_slot_d = idx32[SLOT_W-1:0];
          res_gen_d  = gen_ctr_q;
          gen_ctr_d  = gen_ctr_q + GEN_W'(1);
          state_d    = S_DONE;
        end else if (word_q == LAST_WORD) begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end else begin
          word_d = word_q + WAW'(1);
        end
      end
      S_HCHK: begin
        if (h_ok && (op_q == OP_REMOVE)) begin
          life_we    = 1'b1;
          life_wdata[lane_q*LIFE_W +: LIFE_W] = LS_PEND_REM;
        end
        res_status_d = h_ok ? ST_OK : ST_INVALID;
        state_d      = S_DONE;
      end
      S_COMMIT: begin
        life_we    = 1'b1;
        life_wdata = commit_word;
        if (word_q == LAST_WORD) begin
          state_d = S_DONE;
        end else begin
          word_d = word_q + WAW'(1);
        end
      end
      S_QLIFE: begin
        if (|vec.live) begin
          ql        = first_set(vec.live);
          q_idx     = {word_q, ql};
          lane_d    = ql;
          cand_d    = vec.live & ~(LANES'(1) << ql);
          tbl_raddr = q_idx[IDX_W-1:0];
          state_d   = S_QMASK;
        end else if (word_q == LAST_WORD) begin
          res_status_d = ST_NOMATCH;
          state_d      = S_DONE;
        end else begin
          word_d    = word_q + WAW'(1);
          lo_lane_d = '0;
        end
      end
      S_QMASK: begin
        if ((mask_rdata & mask_q) == mask_q) begin
          res_status_d = ST_OK;
          res_slot_d   = idx32[SLOT_W-1:0];
          res_gen_d    = gen_rdata;
          state_d      = S_DONE;
        end else if (|cand_q) begin
          ql        = first_set(cand_q);
          q_idx     = {word_q, ql};
          lane_d    = ql;
          cand_d    = cand_q & ~(LANES'(1) << ql);
          tbl_raddr = q_idx[IDX_W-1:0];
        end else if (word_q == LAST_WORD) begin
          res_status_d = ST_NOMATCH;
          state_d      = S_DONE;
        end else begin
          word_d    = word_q + WAW'(1);
          lo_lane_d = '0;
          state_d   = S_QLIFE;
        end
      end
      S_DONE: begin
        if (go_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      word_q      <= '0;
      gen_ctr_q   <= GEN_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      word_q    <= word_d;
      gen_ctr_q <= gen_ctr_d;
      if (go_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q       <= lane_d;
    lo_lane_q    <= lo_lane_d;
    cand_q       <= cand_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_gen_q    <= res_gen_d;
    if (in_valid_i && in_ready_o) begin
      op_q     <= operation_i;
      allow_q  <= allow_pending_i;
      gen_in_q <= generation_i;
      mask_q   <= mask_i;
    end
    if (go_done) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_gen_q    <= res_gen_q;
    end
  end

  `GEST_ASSERT_RST(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q != S_IDLE, "Accepted transaction did not start work")
  `GEST_ASSERT_RST(a_gen_counter_step, (gen_ctr_q != $past(gen_ctr_q)) |-> (gen_ctr_q == $past(gen_ctr_q) + 32'd1), "Generation counter moved by other than one")
  `GEST_ASSERT_RST(a_miss_payload, out_valid_o && (status_o == ST_FULL || status_o == ST_INVALID || status_o == ST_NOMATCH) |-> (result_slot_o == '1 && result_generation_o == '0), "Failed transaction carries a slot or generation")
  `GEST_ASSERT_ANY(a_life_write_state, life_we |-> (state_q == S_CLEAR || state_q == S_ADD || state_q == S_HCHK || state_q == S_COMMIT), "Life table written outside a writing step")

endmodule
